>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the predictor RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/sfpp_pkg.sv
// Types and constants for the stereo fixed polynomial predictor.
// Depends on nothing; used by every module of the block.
package sfpp_pkg;

	localparam int unsigned FIELD_BITS = 16;
	localparam int unsigned DATA_BITS  = 2 * FIELD_BITS;
	localparam int unsigned APB_BITS   = 32;
	localparam int unsigned ADDR_BITS  = 3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_DIR   = 1'b1;

	localparam logic [1:0] ORD_ZERO  = 2'd0;
	localparam logic [1:0] ORD_ONE   = 2'd1;
	localparam logic [1:0] ORD_TWO   = 2'd2;
	localparam logic [1:0] ORD_THREE = 2'd3;

	localparam logic [1:0] WARM_MAX  = 2'd3;

	typedef struct packed {
		logic [1:0] order;
		logic       dir;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       warm;
		logic       dec;
		logic [1:0] ord;
	} chan_ctrl_t;

endpackage

>>> hw/rtl/sfpp_cfg.sv
// Configuration register file with an APB-style port.
// Depends on sfpp_pkg for the register indexes and the cfg_t type.
module sfpp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sfpp_pkg::ADDR_BITS-1:0] paddr,
	input  logic [sfpp_pkg::APB_BITS-1:0]  pwdata,
	output logic [sfpp_pkg::APB_BITS-1:0]  prdata,
	output logic                           pready,
	output sfpp_pkg::cfg_t                 cfg
);
	import sfpp_pkg::*;

	logic [1:0] order_q;
	logic       dir_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_ONE;
			dir_q   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ORDER: order_q <= pwdata[1:0];
				REG_DIR:   dir_q   <= pwdata[0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ORDER: prdata = {{(APB_BITS-2){1'b0}}, order_q};
			REG_DIR:   prdata = {{(APB_BITS-1){1'b0}}, dir_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.order = order_q;
	assign cfg.dir   = dir_q;

endmodule

>>> hw/rtl/sfpp_chan.sv
// One channel of the predictor: three-sample history and the residual datapath.
// Depends on sfpp_pkg for chan_ctrl_t and the order codes.
`include "assert_macros.svh"

module sfpp_chan #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfpp_pkg::chan_ctrl_t   ctrl,
	input  logic [SAMPLE_BITS-1:0] din,
	output logic [SAMPLE_BITS-1:0] res
);
	import sfpp_pkg::*;

	logic [SAMPLE_BITS-1:0] h0_q;
	logic [SAMPLE_BITS-1:0] h1_q;
	logic [SAMPLE_BITS-1:0] h2_q;
	logic [SAMPLE_BITS-1:0] pred;
	logic [SAMPLE_BITS-1:0] sample;

	always_comb begin
		case (ctrl.ord)
			ORD_ONE: pred = h0_q;
			ORD_TWO: pred = (h0_q << 1) - h1_q;
			default: pred = (h0_q << 1) + h0_q - ((h1_q << 1) + h1_q) + h2_q;
		endcase
	end

	always_comb begin
		if (ctrl.warm) begin
			sample = din;
			res    = din;
		end else if (ctrl.dec) begin
			sample = din + pred;
			res    = sample;
		end else begin
			sample = din;
			res    = din - pred;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q <= '0;
			h1_q <= '0;
			h2_q <= '0;
		end else if (ctrl.load) begin
			h2_q <= h1_q;
			h1_q <= h0_q;
			h0_q <= sample;
		end
	end

	`ASSERT_NEXT(a_warm_keeps_input, clk, arst_n, ctrl.load && ctrl.warm, h0_q == $past(din))
	`ASSERT_NEXT(a_hist_shift, clk, arst_n, ctrl.load, h1_q == $past(h0_q) && h2_q == $past(h1_q))
	`ASSERT_SAME(a_warm_passes, clk, arst_n, ctrl.load && ctrl.warm, res == din)

endmodule

>>> hw/rtl/stereo_fixed_polynomial_predictor.sv
// Stereo fixed polynomial predictor: one stereo frame in, one frame out.
// Each frame on the slave stream carries left and right values; in encode
// direction they are samples and the result is the prediction residual, in
// decode direction they are residuals and the result is the sample.
// s_tuser high marks the first frame of a new stream and restarts warm-up:
// the first 'order' frames of a stream (three for order 0) pass unchanged.
// Registers over APB: order at address 0, direction at address 4. The user
// must see that they are written only while no transaction is in flight;
// the block itself does not enforce this. An accepted frame is captured
// in the input register and then moves on to the output register, which
// drives m_tvalid. Throughput is one frame per cycle while the receiver
// does not stall; each channel closes its history loop through the
// predictor adder. A stalled receiver holds the output register; the
// input register still takes a frame while the output one is free or
// being drained, and s_tready falls once both are full. Reset clears the
// histories, the warm-up count, both stages and sets the order to one and
// the direction to encode. Depends on sfpp_pkg, sfpp_cfg and sfpp_chan.
`include "assert_macros.svh"

module stereo_fixed_polynomial_predictor #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sfpp_pkg::DATA_BITS-1:0]  s_tdata, // left_in, right_in
	input  logic                            s_tuser, // stream_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sfpp_pkg::DATA_BITS-1:0]  m_tdata, // left_out, right_out
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sfpp_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [sfpp_pkg::APB_BITS-1:0]   pwdata,
	output logic [sfpp_pkg::APB_BITS-1:0]   prdata,
	output logic                            pready
);
	import sfpp_pkg::*;

	cfg_t                   cfg;
	chan_ctrl_t             ctrl;
	logic                   valid_s1;
	logic [FIELD_BITS-1:0]  left_s1;
	logic [FIELD_BITS-1:0]  right_s1;
	logic                   start_s1;
	logic                   out_valid_q;
	logic [DATA_BITS-1:0]   out_data_q;
	logic [1:0]             warm_q;
	logic [1:0]             warm_eff;
	logic [1:0]             ord_eff;
	logic                   advance;
	logic [SAMPLE_BITS-1:0] left_w;
	logic [SAMPLE_BITS-1:0] right_w;
	logic [SAMPLE_BITS-1:0] left_res;
	logic [SAMPLE_BITS-1:0] right_res;

	sfpp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			left_s1  <= s_tdata[FIELD_BITS-1:0];
			right_s1 <= s_tdata[DATA_BITS-1:FIELD_BITS];
			start_s1 <= s_tuser;
		end
	end

	assign ord_eff  = (cfg.order == ORD_ZERO) ? ORD_THREE : cfg.order;
	assign warm_eff = start_s1 ? 2'd0 : warm_q;

	assign ctrl.load = valid_s1 && advance;
	assign ctrl.warm = warm_eff < ord_eff;
	assign ctrl.dec  = cfg.dir;
	assign ctrl.ord  = ord_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= 2'd0;
		end else if (ctrl.load) begin
			warm_q <= (warm_eff == WARM_MAX) ? WARM_MAX : warm_eff + 2'd1;
		end
	end

	assign left_w  = SAMPLE_BITS'(left_s1);
	assign right_w = SAMPLE_BITS'(right_s1);

	sfpp_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.din    (left_w),
		.res    (left_res)
	);

	sfpp_chan #(.SAMPLE_BITS(SAMPLE_BITS)) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.din    (right_w),
		.res    (right_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			out_data_q <= {FIELD_BITS'($signed(right_res)), FIELD_BITS'($signed(left_res))};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(left_s1))
	`ASSERT_NEXT(a_accept_fills, clk, arst_n, s_tvalid && s_tready, valid_s1)
	`ASSERT_NEXT(a_load_fills_out, clk, arst_n, ctrl.load, out_valid_q)
	`ASSERT_NEXT(a_start_restarts, clk, arst_n, ctrl.load && start_s1, warm_q == 2'd1)

endmodule
